### hw/rtl/rrv_pkg.sv
// Shared types and constants for the rolling return volatility block.
package rrv_pkg;

  localparam int unsigned PriceW = 32;
  localparam int unsigned RetW   = 34;                    // signed Q2.30 with headroom
  localparam logic [31:0] VolScale = 32'd104035175;      // sqrt(252)*100 in Q16.16
  localparam logic [33:0] RetSat   = 34'h0BFFFFFFF;       // largest quotient kept

  typedef enum logic [1:0] {
    StatusValid   = 2'd0,
    StatusTooFew  = 2'd1,
    StatusZeroPri = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OpNone    = 4'd0,
    OpStore   = 4'd1,
    OpDivIni  = 4'd2,
    OpDivStp  = 4'd3,
    OpRetAcc  = 4'd4,
    OpMean    = 4'd5,
    OpSqAcc   = 4'd6,
    OpVarIni  = 4'd7,
    OpCdMul   = 4'd8,
    OpSqrIni  = 4'd9,
    OpSqrStp  = 4'd10,
    OpMul     = 4'd11,
    OpRound   = 4'd12,
    OpCdFix   = 4'd13,
    OpMeanIni = 4'd14
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [6:0]  idx;
    logic        fresh;
  } cmd_t;

  typedef struct packed {
    logic        too_few;
    logic        zero_prior;
    logic        unit_done;
  } stat_t;

endpackage

### hw/rtl/rrv_datapath.sv
// Datapath: close history, return divider, accumulators, square root and scaling.
module rrv_datapath #(
  parameter int unsigned Window = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         close_price_i,
  input  rrv_pkg::cmd_t       cmd_i,
  output rrv_pkg::stat_t      stat_o,
  output logic [31:0]         result_o
);
  localparam int unsigned Depth = Window + 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned SumW  = 34 + $clog2(Window) + 1;
  localparam int unsigned AccW  = 62 + $clog2(Window) + 1;

  // reciprocals for the divisions by the window constants
  localparam logic [63:0] RcpMean = 64'hFFFF_FFFF_FFFF_FFFF / 64'(Window);
  localparam logic [63:0] RcpVar  = 64'hFFFF_FFFF_FFFF_FFFF / 64'(Window - 1);

  logic [31:0]     hist_q [Depth];
  logic [CntW-1:0] seen_q;
  logic [Depth-1:0] zero_q;  // zero flag per entry

  // divider state for the returns
  logic [AccW-1:0] dnum_q;
  logic [AccW-1:0] drem_q;
  logic [AccW-1:0] dquo_q;
  logic [AccW-1:0] dden_q;
  logic [6:0]      dcnt_q;

  // constant divider state (mean and variance)
  logic [63:0]     cx_q, cm_q, cq_q;
  logic [6:0]      cd_q;
  logic [127:0]    cacc_q;

  logic signed [SumW-1:0] sum_q;
  logic signed [33:0]     mean_q;
  logic signed [33:0]     rets_q [Window];
  logic [AccW-1:0]        acc_q;
  logic [63:0]            sv_q, sres_q, sbit_q;
  logic [63:0]            prod_q;
  logic [31:0]            result_q;

  logic [IdxW-1:0] ri;
  assign ri = cmd_i.idx[IdxW-1:0];

  // one restoring division step
  logic [AccW:0]   trial;
  logic [AccW-1:0] rem_sh;
  assign rem_sh = {drem_q[AccW-2:0], dnum_q[AccW-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dden_q};

  logic [33:0] qsat;
  assign qsat = (dquo_q > AccW'(rrv_pkg::RetSat)) ? rrv_pkg::RetSat : dquo_q[33:0];

  logic signed [34:0] dev;
  logic [67:0]        dsq;
  assign dev = 35'(rets_q[ri]) - 35'(mean_q);
  assign dsq = 68'((dev[34] ? -dev : dev)) * 68'((dev[34] ? -dev : dev));

  logic [63:0] sgo;
  assign sgo = sres_q + sbit_q;

  logic [SumW-1:0] sum_abs;
  assign sum_abs = sum_q[SumW-1] ? -sum_q : sum_q;

  // one 32x32 partial product of dividend times reciprocal per cycle
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  assign pa = cmd_i.idx[1] ? cx_q[63:32] : cx_q[31:0];
  assign pb = cmd_i.idx[0] ? cm_q[63:32] : cm_q[31:0];
  assign pp = pa * pb;

  always_comb begin
    case (cmd_i.idx[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // estimate is exact or one short; the remainder decides
  logic [63:0] qe, qd, qrem;
  assign qe   = cacc_q[127:64];
  assign qd   = qe * {57'd0, cd_q};
  assign qrem = cx_q - qd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      zero_q <= '0;
    end else if (cmd_i.op == rrv_pkg::OpStore) begin
      if (cmd_i.fresh || (seen_q < CntW'(Depth))) begin
        seen_q <= cmd_i.fresh ? CntW'(1) : seen_q + 1'b1;
        zero_q[cmd_i.fresh ? '0 : seen_q[IdxW-1:0]] <= (close_price_i == '0);
      end else begin
        zero_q <= {(close_price_i == '0), zero_q[Depth-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rrv_pkg::OpStore: begin
        if (cmd_i.fresh) hist_q[0] <= close_price_i;
        else if (seen_q < CntW'(Depth)) hist_q[seen_q[IdxW-1:0]] <= close_price_i;
        else begin
          for (int i = 0; i < Depth - 1; i++) hist_q[i] <= hist_q[i+1];
          hist_q[Depth-1] <= close_price_i;
        end
        sum_q <= '0;
        acc_q <= '0;
      end
      rrv_pkg::OpDivIni: begin
        dnum_q <= AccW'({hist_q[ri + 1'b1], 30'd0}) << (AccW - 62);
        dden_q <= AccW'(hist_q[ri]);
        drem_q <= '0;
        dquo_q <= '0;
        dcnt_q <= 7'd62;
      end
      rrv_pkg::OpDivStp: begin
        dnum_q <= dnum_q << 1;
        dcnt_q <= dcnt_q - 1'b1;
        if (!trial[AccW]) begin
          drem_q <= trial[AccW-1:0];
          dquo_q <= {dquo_q[AccW-2:0], 1'b1};
        end else begin
          drem_q <= rem_sh;
          dquo_q <= {dquo_q[AccW-2:0], 1'b0};
        end
      end
      rrv_pkg::OpMeanIni: begin
        cx_q   <= 64'(sum_abs);
        cm_q   <= RcpMean;
        cd_q   <= 7'(Window);
        cacc_q <= '0;
      end
      rrv_pkg::OpVarIni: begin
        cx_q   <= acc_q[63:0];
        cm_q   <= RcpVar;
        cd_q   <= 7'(Window - 1);
        cacc_q <= '0;
      end
      rrv_pkg::OpCdMul: begin
        cacc_q <= cacc_q + pp_sh;
      end
      rrv_pkg::OpCdFix: begin
        cq_q <= (qrem >= {57'd0, cd_q}) ? qe + 64'd1 : qe;
      end
      rrv_pkg::OpRetAcc: begin
        rets_q[cmd_i.idx[$clog2(Window)-1:0]] <= $signed(qsat) - 34'sh40000000;
        sum_q <= sum_q + SumW'($signed(qsat) - 34'sh40000000);
      end
      rrv_pkg::OpMean: begin
        // truncate toward zero: quotient of the magnitude, sign put back
        mean_q <= sum_q[SumW-1] ? -$signed(cq_q[33:0]) : $signed(cq_q[33:0]);
      end
      rrv_pkg::OpSqAcc: begin
        acc_q <= acc_q + AccW'(dsq >> 8);
      end
      rrv_pkg::OpSqrIni: begin
        sv_q   <= cq_q;
        sres_q <= '0;
        sbit_q <= 64'h4000000000000000;
      end
      rrv_pkg::OpSqrStp: begin
        if (sv_q >= sgo) begin
          sv_q   <= sv_q - sgo;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      rrv_pkg::OpMul: begin
        prod_q <= sres_q[31:0] * rrv_pkg::VolScale;
      end
      rrv_pkg::OpRound: begin
        result_q <= ((prod_q + 64'd33554432) >> 26) > 64'hFFFFFFFF ? 32'hFFFFFFFF
                  : 32'((prod_q + 64'd33554432) >> 26);
      end
      default: ;
    endcase
  end

  assign stat_o.too_few    = seen_q < CntW'(Depth);
  assign stat_o.zero_prior = |zero_q[Depth-2:0];
  assign stat_o.unit_done  = (cmd_i.op == rrv_pkg::OpSqrStp) ? (sbit_q[1:0] != 2'd0)
                           : (dcnt_q == 7'd1);
  assign result_o = result_q;
endmodule

### hw/rtl/rrv_ctrl.sv
// Sequencer that steps the datapath through one close.
module rrv_ctrl #(
  parameter int unsigned Window = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           new_series_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     status_o,
  output logic           use_result_o,
  output rrv_pkg::cmd_t  cmd_o,
  input  rrv_pkg::stat_t stat_i
);
  typedef enum logic [10:0] {
    StIdle = 11'b00000000001, StChk  = 11'b00000000010, StDivI = 11'b00000000100,
    StDivS = 11'b00000001000, StRet  = 11'b00000010000, StMean = 11'b00000100000,
    StSq   = 11'b00001000000, StVarI = 11'b00010000000, StVarS = 11'b00100000000,
    StSqrt = 11'b01000000000, StOut  = 11'b10000000000
  } state_e;

  state_e     st_q, st_d;
  logic [6:0] idx_q, idx_d;
  logic [1:0] phase_q, phase_d;   // sub-step within mean, variance and sqrt
  logic       ov_q, ov_d;
  logic [1:0] status_q, status_d;
  logic       use_q, use_d;

  always_comb begin
    st_d = st_q; idx_d = idx_q; phase_d = phase_q;
    ov_d = ov_q; status_d = status_q; use_d = use_q;
    cmd_o = '{op: rrv_pkg::OpNone, idx: idx_q, fresh: new_series_i};
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      StIdle: if (in_valid_i && !ov_q) begin
        cmd_o.op = rrv_pkg::OpStore;
        st_d = StChk;
      end
      StChk: begin
        idx_d = '0;
        if (stat_i.too_few) begin
          status_d = rrv_pkg::StatusTooFew; use_d = 1'b0; st_d = StOut;
        end else if (stat_i.zero_prior) begin
          status_d = rrv_pkg::StatusZeroPri; use_d = 1'b0; st_d = StOut;
        end else begin
          status_d = rrv_pkg::StatusValid; use_d = 1'b1; st_d = StDivI;
        end
      end
      StDivI: begin cmd_o.op = rrv_pkg::OpDivIni; st_d = StDivS; end
      StDivS: begin
        cmd_o.op = rrv_pkg::OpDivStp;
        if (stat_i.unit_done) st_d = StRet;
      end
      StRet: begin
        cmd_o.op = rrv_pkg::OpRetAcc;
        if (idx_q == 7'(Window - 1)) begin
          idx_d = '0; phase_d = 2'd0; st_d = StMean;
        end
        else begin idx_d = idx_q + 1'b1; st_d = StDivI; end
      end
      StMean: begin
        case (phase_q)
          2'd0: begin cmd_o.op = rrv_pkg::OpMeanIni; phase_d = 2'd1; end
          2'd1: begin
            cmd_o.op = rrv_pkg::OpCdMul;
            if (idx_q == 7'd3) begin idx_d = '0; phase_d = 2'd2; end
            else idx_d = idx_q + 1'b1;
          end
          2'd2: begin cmd_o.op = rrv_pkg::OpCdFix; phase_d = 2'd3; end
          default: begin
            cmd_o.op = rrv_pkg::OpMean; phase_d = 2'd0; st_d = StSq;
          end
        endcase
      end
      StSq: begin
        cmd_o.op = rrv_pkg::OpSqAcc;
        if (idx_q == 7'(Window - 1)) st_d = StVarI;
        else idx_d = idx_q + 1'b1;
      end
      StVarI: begin
        cmd_o.op = rrv_pkg::OpVarIni; idx_d = '0; phase_d = 2'd0; st_d = StVarS;
      end
      StVarS: begin
        case (phase_q)
          2'd0: begin
            cmd_o.op = rrv_pkg::OpCdMul;
            if (idx_q == 7'd3) begin idx_d = '0; phase_d = 2'd1; end
            else idx_d = idx_q + 1'b1;
          end
          default: begin
            cmd_o.op = rrv_pkg::OpCdFix; phase_d = 2'd0; st_d = StSqrt;
          end
        endcase
      end
      StSqrt: begin
        case (phase_q)
          2'd0: begin cmd_o.op = rrv_pkg::OpSqrIni; phase_d = 2'd1; end
          2'd1: begin
            cmd_o.op = rrv_pkg::OpSqrStp;
            if (stat_i.unit_done) phase_d = 2'd2;
          end
          2'd2: begin cmd_o.op = rrv_pkg::OpMul; phase_d = 2'd3; end
          default: begin cmd_o.op = rrv_pkg::OpRound; st_d = StOut; end
        endcase
      end
      StOut: if (!ov_q) begin ov_d = 1'b1; st_d = StIdle; end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; idx_q <= '0; phase_q <= '0;
      ov_q <= 1'b0; status_q <= '0; use_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; phase_q <= phase_d;
      ov_q <= ov_d; status_q <= status_d; use_q <= use_d;
    end
  end

  assign in_ready_o   = (st_q == StIdle) && !ov_q;
  assign out_valid_o  = ov_q;
  assign status_o     = status_q;
  assign use_result_o = use_q;
endmodule

### hw/rtl/rolling_return_volatility_top.sv
// Top level of the rolling annualized return volatility block.
//
//  channel | signals                                  | direction
//  in      | in_valid_i/in_ready_o, close_price_i,    | request in
//          | new_series_i                             |
//  out     | out_valid_o/out_ready_i,                 | request out
//          | volatility_pct_o, status_o               |
//
// One close at a time. After its request is taken and checked, a full result goes
// through the returns (62-step restoring divider per return), the mean, the squared
// deviations and the variance (reciprocal multiply in four 32x32 partial products
// plus one correction for each), then the 32-step square root and scaling. Short
// series, and series with a zero among the prior closes, skip from check to output.
// The result register holds until taken; the next close is accepted only
// after it leaves. Reset clears the close count, the sequencer and valid.
module rolling_return_volatility_top #(
  parameter int unsigned WINDOW = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] close_price_i,
  input  logic        new_series_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] volatility_pct_o,
  output logic [1:0]  status_o
);
  rrv_pkg::cmd_t  cmd;
  rrv_pkg::stat_t stat;
  logic [31:0]    result;
  logic           use_result;

  rrv_datapath #(.Window(WINDOW)) u_dp (
    .clk_i, .rst_ni, .close_price_i, .cmd_i(cmd), .stat_o(stat), .result_o(result)
  );

  rrv_ctrl #(.Window(WINDOW)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .new_series_i,
    .out_valid_o, .out_ready_i, .status_o, .use_result_o(use_result),
    .cmd_o(cmd), .stat_i(stat)
  );

  // zero volatility whenever the status flags a problem
  assign volatility_pct_o = use_result ? result : 32'd0;
endmodule

### bench/tb_rolling_return_volatility_top.sv
// Self-checking testbench for the rolling return volatility top level.
`timescale 1ns / 1ps

module tb_rolling_return_volatility_top;

  localparam int unsigned Win       = 20;
  localparam int unsigned Depth     = Win + 1;
  localparam int unsigned NumItems  = 1150;
  localparam int unsigned DrainWait = 100;
  localparam longint unsigned CycleLimit = 64'd8_000_000;

  typedef struct packed {
    logic [31:0]       vol;
    rrv_pkg::status_e  status;
  } vol_result_t;

  // One directed run: a close repeated count times, with an optional typed answer.
  typedef struct {
    logic [31:0]       price;
    logic              fresh;
    int                count;
    logic              typed;
    logic [31:0]       vol;
    rrv_pkg::status_e  status;
  } run_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] close_price_i = '0;
  logic        new_series_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] volatility_pct_o;
  logic [1:0]  status_o;

  // Own copy of the close history and count.
  logic [31:0] hist_q [Depth];
  int unsigned seen_q;

  vol_result_t pending_vols[$];
  int unsigned mismatch_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  longint unsigned cycle_cnt;

  rolling_return_volatility_top #(.WINDOW(Win)) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .close_price_i,
    .new_series_i,
    .out_valid_o,
    .out_ready_i,
    .volatility_pct_o,
    .status_o
  );

  always #5 clk_i = ~clk_i;

  // Integer square root, bit by bit.
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Advance the history by one close and work out the annualized volatility.
  function automatic vol_result_t predict_volatility(logic [31:0] price, logic fresh);
    vol_result_t r;
    longint signed rets [Win];
    longint signed sum;
    longint signed mean;
    longint signed d;
    logic [63:0] q;
    logic [63:0] ad;
    logic [63:0] acc;
    logic [63:0] var_q;
    logic [63:0] prod;
    if (fresh) seen_q = 0;
    if (seen_q < Depth) begin
      hist_q[seen_q] = price;
      seen_q++;
    end else begin
      for (int i = 0; i < Win; i++) hist_q[i] = hist_q[i+1];
      hist_q[Win] = price;
    end
    r.vol = '0;
    if (seen_q < Depth) begin
      r.status = rrv_pkg::StatusTooFew;
      return r;
    end
    for (int i = 0; i < Win; i++) begin
      if (hist_q[i] == 0) begin
        r.status = rrv_pkg::StatusZeroPri;
        return r;
      end
    end
    sum = 0;
    for (int i = 0; i < Win; i++) begin
      q = ({32'd0, hist_q[i+1]} << 30) / {32'd0, hist_q[i]};
      if (q > 64'hBFFF_FFFF) q = 64'hBFFF_FFFF;
      rets[i] = longint'(q) - 64'sh4000_0000;
      sum += rets[i];
    end
    mean = sum / longint'(Win);
    acc = '0;
    for (int i = 0; i < Win; i++) begin
      d = rets[i] - mean;
      ad = (d < 0) ? 64'(-d) : 64'(d);
      acc += (ad * ad) >> 8;
    end
    var_q = acc / 64'(Win - 1);
    prod = (int_sqrt(var_q) * 64'(rrv_pkg::VolScale) + (64'd1 << 25)) >> 26;
    r.vol = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
    r.status = rrv_pkg::StatusValid;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Send one request: hold valid until taken, then log its expected result.
  task automatic send_close(logic [31:0] price, logic fresh, logic typed,
                            vol_result_t typed_res);
    vol_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    close_price_i <= price;
    new_series_i  <= fresh;
    do @(posedge clk_i); while (!in_ready_o);
    pred = predict_volatility(price, fresh);
    pending_vols.insert(pending_vols.size(), typed ? typed_res : pred);
  endtask

  // Random close near the previous one, with the odd wild value or zero.
  function automatic logic [31:0] next_close(logic [31:0] prev, int unsigned zero_pct);
    logic [31:0] span;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < zero_pct) return '0;
    if (pick < zero_pct + 6 || prev == 0) return $urandom();
    span = (prev >> 4) + 1;
    return prev - (span >> 1) + $urandom_range(0, span);
  endfunction

  // Take results at random, compare against the oldest expectation.
  always @(posedge clk_i) begin
    vol_result_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_vols.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_vols.pop_front();
        if (volatility_pct_o !== want.vol)
          report_mismatch($sformatf("volatility %h, expected %h", volatility_pct_o, want.vol));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Bound the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    run_row_t runs [4];
    vol_result_t typed_res;
    logic [31:0] price;
    int unsigned sent;
    int unsigned seq_len;
    int unsigned zero_pct;
    int unsigned drain;

    mismatch_cnt  = 0;
    cycle_cnt     = 0;
    seen_q        = 0;
    send_idle_pct = 21;
    recv_idle_pct = 79;
    foreach (hist_q[i]) hist_q[i] = '0;

    // Flat prices give zero volatility once the window fills; then extremes.
    runs[0] = '{32'h0001_0000, 1'b0, Win, 1'b1, 32'd0, rrv_pkg::StatusTooFew};
    runs[1] = '{32'h0001_0000, 1'b0, 1,   1'b1, 32'd0, rrv_pkg::StatusValid};
    runs[2] = '{32'hFFFF_FFFF, 1'b1, 1,   1'b1, 32'd0, rrv_pkg::StatusTooFew};
    runs[3] = '{32'h0000_0000, 1'b0, 1,   1'b1, 32'd0, rrv_pkg::StatusTooFew};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sent = 0;
    foreach (runs[r]) begin
      for (int k = 0; k < runs[r].count; k++) begin
        typed_res.vol    = runs[r].vol;
        typed_res.status = runs[r].status;
        send_close(runs[r].price, runs[r].fresh, runs[r].typed, typed_res);
        sent++;
      end
    end

    // Random series: mostly long enough to fill the window, some short.
    price = 32'h0064_0000;
    while (sent < NumItems) begin
      if (sent > NumItems / 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 21;
      end
      if (sent > 2 * NumItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      seq_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, Win) :
                                               $urandom_range(Depth, Depth + 8);
      zero_pct = ($urandom_range(0, 4) == 0) ? 3 : 0;
      price    = ($urandom_range(0, 3) == 0) ? $urandom() :
                                               $urandom_range(32'h0000_0100, 32'h0FFF_FFFF);
      for (int k = 0; k < seq_len && sent < NumItems; k++) begin
        send_close(price, (k == 0) || ($urandom_range(0, 99) == 0), 1'b0, typed_res);
        sent++;
        price = next_close(price, zero_pct);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_vols.size() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < DrainWait) begin
      @(posedge clk_i);
      drain++;
    end

    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
